// File: hdl/nand_block_page_state_tracker_assert.svh
// Assertion macros used by the page state tracker controller RTL.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef NAND_BLOCK_PAGE_STATE_TRACKER_ASSERT_SVH
`define NAND_BLOCK_PAGE_STATE_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define NBPST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nbpst: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define NBPST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nbpst: assertion failed");

`endif

// File: hdl/nbpst_pkg.sv
// Shared types, codes and constants of the NAND block/page state tracker.
// Used by every module of the block but nbpst_ram; depends on nothing.
package nbpst_pkg;

  // Default geometry limits (top-level parameter defaults)
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_MAX_DIES     = 2;
  localparam int DEF_MAX_PLANES   = 2;
  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_MAX_PAGES    = 64;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 56;
  localparam int STATUS_W = 2;
  localparam int COND_W   = 2;
  localparam int WEAR_W   = 20;
  localparam int COUNT_W  = 7;

  // Stream payload layout
  localparam int S_TDATA_W    = 64;
  localparam int IN_CMD_LSB   = 0;
  localparam int IN_ADDR_LSB  = IN_CMD_LSB + CMD_W;
  localparam int IN_FAULT_BIT = IN_ADDR_LSB + ADDR_W;
  localparam int M_TDATA_W    = 40;

  // Physical address layout
  localparam int PG_LSB = 0;
  localparam int PG_W   = 16;
  localparam int BLK_LSB = 16;
  localparam int BLK_W  = 16;
  localparam int PL_LSB = 32;
  localparam int PL_W   = 8;
  localparam int DIE_LSB = 40;
  localparam int DIE_W  = 8;
  localparam int CH_LSB = 48;
  localparam int CH_W   = 8;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int CFG_CH_W  = 3;
  localparam int CFG_DIE_W = 2;
  localparam int CFG_PL_W  = 2;
  localparam int CFG_BLK_W = 7;
  localparam int CFG_PG_W  = 7;

  typedef enum logic [2:0] {
    REG_CHANNELS = 3'd0,
    REG_DIES     = 3'd1,
    REG_PLANES   = 3'd2,
    REG_BLOCKS   = 3'd3,
    REG_PAGES    = 3'd4
  } reg_idx_e;

  localparam logic [CFG_CH_W-1:0]  CFG_RST_CHANNELS = 3'd4;
  localparam logic [CFG_DIE_W-1:0] CFG_RST_DIES     = 2'd2;
  localparam logic [CFG_PL_W-1:0]  CFG_RST_PLANES   = 2'd2;
  localparam logic [CFG_BLK_W-1:0] CFG_RST_BLOCKS   = 7'd64;
  localparam logic [CFG_PG_W-1:0]  CFG_RST_PAGES    = 7'd64;

  typedef struct packed {
    logic [CFG_CH_W-1:0]  channels;
    logic [CFG_DIE_W-1:0] dies;
    logic [CFG_PL_W-1:0]  planes;
    logic [CFG_BLK_W-1:0] blocks;
    logic [CFG_PG_W-1:0]  pages;
  } cfg_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ     = 2'd0,
    CMD_PROGRAM  = 2'd1,
    CMD_ERASE    = 2'd2,
    CMD_MARK_BAD = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DEV_ERR = 2'd2,
    ST_WRITTEN = 2'd3
  } status_e;

  typedef enum logic [COND_W-1:0] {
    COND_FREE = 2'd0,
    COND_OPEN = 2'd1,
    COND_FULL = 2'd2,
    COND_BAD  = 2'd3
  } cond_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic clr_wr;  // write one zero entry of the clearing sweep
    logic load;    // capture the accepted command, launch metadata read
    logic exec;    // update metadata, write back, load result register
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clr_last;  // sweep is at its last entry
  } dp_status_t;

endpackage

// File: hdl/nbpst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the per-block metadata store.
module nbpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/nbpst_regs.sv
// APB configuration registers (geometry in use) of the state tracker.
// Depends on nbpst_pkg.
module nbpst_regs
  import nbpst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);

  // Register writes; unmapped indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channels <= CFG_RST_CHANNELS;
      cfg_q.dies     <= CFG_RST_DIES;
      cfg_q.planes   <= CFG_RST_PLANES;
      cfg_q.blocks   <= CFG_RST_BLOCKS;
      cfg_q.pages    <= CFG_RST_PAGES;
    end else if (wr_en) begin
      case (idx)
        REG_CHANNELS: cfg_q.channels <= pwdata[CFG_CH_W-1:0];
        REG_DIES:     cfg_q.dies     <= pwdata[CFG_DIE_W-1:0];
        REG_PLANES:   cfg_q.planes   <= pwdata[CFG_PL_W-1:0];
        REG_BLOCKS:   cfg_q.blocks   <= pwdata[CFG_BLK_W-1:0];
        REG_PAGES:    cfg_q.pages    <= pwdata[CFG_PG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_CHANNELS: prdata = APB_DW'(cfg_q.channels);
      REG_DIES:     prdata = APB_DW'(cfg_q.dies);
      REG_PLANES:   prdata = APB_DW'(cfg_q.planes);
      REG_BLOCKS:   prdata = APB_DW'(cfg_q.blocks);
      REG_PAGES:    prdata = APB_DW'(cfg_q.pages);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/nbpst_ctrl.sv
// Controller FSM of the state tracker: clearing sweep, accept, execute.
// Depends on nbpst_pkg and the assertion macro header.
`include "nand_block_page_state_tracker_assert.svh"

module nbpst_ctrl
  import nbpst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   slot_free;

  assign slot_free = !m_valid_q || m_ready_i;

  // Commands to the datapath
  assign cmd_o.clr_wr = (state_q == ST_CLEAR);
  assign cmd_o.load   = (state_q == ST_IDLE) && s_valid_i;
  assign cmd_o.exec   = (state_q == ST_EXEC) && slot_free;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  // Next state and result-valid flag
  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  `NBPST_ASSERT_NEXT(a_accept_goes_exec, clk_i, rst_ni, s_valid_i && s_ready_o, state_q == ST_EXEC)
  `NBPST_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, cmd_o.exec, m_valid_q)
  `NBPST_ASSERT_NEXT(a_stall_holds_exec, clk_i, rst_ni, (state_q == ST_EXEC) && !slot_free, (state_q == ST_EXEC) && m_valid_q)
  `NBPST_ASSERT_NEXT(a_sweep_ends_idle, clk_i, rst_ni, cmd_o.clr_wr && status_i.clr_last, (state_q == ST_IDLE) && !m_valid_q)

endmodule

// File: hdl/nbpst_dp.sv
// Datapath of the state tracker: address decode, metadata RAM, update logic,
// result register and clearing-sweep counter. Depends on nbpst_pkg, nbpst_ram.
module nbpst_dp
  import nbpst_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_DIES     = DEF_MAX_DIES,
  parameter int MAX_PLANES   = DEF_MAX_PLANES,
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int MAX_PAGES    = DEF_MAX_PAGES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  cfg_t                 cfg_i,
  input  logic [S_TDATA_W-1:0] in_tdata_i,
  output logic [M_TDATA_W-1:0] out_tdata_o
);

  localparam int BLK_DEPTH = MAX_CHANNELS * MAX_DIES * MAX_PLANES * MAX_BLOCKS;
  localparam int BI_W   = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;
  localparam int CHI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DIEI_W = (MAX_DIES > 1) ? $clog2(MAX_DIES) : 1;
  localparam int PLI_W  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int BLKI_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int PIDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  // Metadata word layout
  localparam int MAP_LSB   = 0;
  localparam int COND_LSB  = MAP_LSB + MAX_PAGES;
  localparam int WEAR_LSB  = COND_LSB + COND_W;
  localparam int VALID_LSB = WEAR_LSB + WEAR_W;
  localparam int NEXT_LSB  = VALID_LSB + COUNT_W;
  localparam int META_W    = NEXT_LSB + COUNT_W;

  localparam logic [MAX_PAGES-1:0] PAGE_ONE = 1;
  localparam logic [BI_W-1:0]      BI_LAST  = BI_W'(BLK_DEPTH - 1);

  // Input fields
  logic [ADDR_W-1:0] in_addr;
  logic [PG_W-1:0]   in_pg;
  logic [BLK_W-1:0]  in_blk;
  logic [PL_W-1:0]   in_pl;
  logic [DIE_W-1:0]  in_die;
  logic [CH_W-1:0]   in_ch;

  assign in_addr = in_tdata_i[IN_ADDR_LSB +: ADDR_W];
  assign in_pg   = in_addr[PG_LSB +: PG_W];
  assign in_blk  = in_addr[BLK_LSB +: BLK_W];
  assign in_pl   = in_addr[PL_LSB +: PL_W];
  assign in_die  = in_addr[DIE_LSB +: DIE_W];
  assign in_ch   = in_addr[CH_LSB +: CH_W];

  // Effective geometry: register clamped to the built limit
  logic [CFG_CH_W-1:0]  n_ch;
  logic [CFG_DIE_W-1:0] n_die;
  logic [CFG_PL_W-1:0]  n_pl;
  logic [CFG_BLK_W-1:0] n_blk;
  logic [CFG_PG_W-1:0]  n_pg;

  assign n_ch  = (32'(cfg_i.channels) > MAX_CHANNELS) ? CFG_CH_W'(MAX_CHANNELS) : cfg_i.channels;
  assign n_die = (32'(cfg_i.dies) > MAX_DIES) ? CFG_DIE_W'(MAX_DIES) : cfg_i.dies;
  assign n_pl  = (32'(cfg_i.planes) > MAX_PLANES) ? CFG_PL_W'(MAX_PLANES) : cfg_i.planes;
  assign n_blk = (32'(cfg_i.blocks) > MAX_BLOCKS) ? CFG_BLK_W'(MAX_BLOCKS) : cfg_i.blocks;
  assign n_pg  = (32'(cfg_i.pages) > MAX_PAGES) ? CFG_PG_W'(MAX_PAGES) : cfg_i.pages;

  // Range checks and flat block index of the incoming command
  logic            in_block_ok;
  logic            in_page_ok;
  logic [BI_W-1:0] in_bi;

  assign in_block_ok = (in_ch < CH_W'(n_ch)) && (in_die < DIE_W'(n_die)) &&
                       (in_pl < PL_W'(n_pl)) && (in_blk < BLK_W'(n_blk));
  assign in_page_ok  = in_pg < PG_W'(n_pg);

  always_comb begin
    in_bi = '0;
    if (in_block_ok) begin
      in_bi = BI_W'(((32'(in_ch[CHI_W-1:0]) * MAX_DIES + 32'(in_die[DIEI_W-1:0]))
                     * MAX_PLANES + 32'(in_pl[PLI_W-1:0])) * MAX_BLOCKS
                    + 32'(in_blk[BLKI_W-1:0]));
    end
  end

  // Command capture at the accepting transfer
  cmd_e             cmd_q;
  logic             fault_q;
  logic             block_ok_q;
  logic             page_ok_q;
  logic [COUNT_W-1:0] pg_q;
  logic [BI_W-1:0]  bi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= cmd_e'(in_tdata_i[IN_CMD_LSB +: CMD_W]);
      fault_q    <= in_tdata_i[IN_FAULT_BIT];
      block_ok_q <= in_block_ok;
      page_ok_q  <= in_page_ok;
      pg_q       <= in_pg[COUNT_W-1:0];
      bi_q       <= in_bi;
    end
  end

  // Clearing sweep counter
  logic [BI_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + BI_W'(1);
    end
  end

  assign status_o.clr_last = (clr_cnt_q == BI_LAST);

  // Metadata store
  logic              ram_we;
  logic [BI_W-1:0]   ram_waddr;
  logic [META_W-1:0] ram_wdata;
  logic [META_W-1:0] ram_rdata;
  logic [META_W-1:0] meta_new;
  logic              addr_ok;

  assign ram_we    = cmd_i.clr_wr || (cmd_i.exec && addr_ok);
  assign ram_waddr = cmd_i.clr_wr ? clr_cnt_q : bi_q;
  assign ram_wdata = cmd_i.clr_wr ? '0 : meta_new;

  nbpst_ram #(
    .WIDTH (META_W),
    .DEPTH (BLK_DEPTH)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (in_bi),
    .rdata_o (ram_rdata)
  );

  // Current metadata of the addressed block
  logic [MAX_PAGES-1:0] old_map;
  cond_e                old_cond;
  logic [WEAR_W-1:0]    old_wear;
  logic [COUNT_W-1:0]   old_valid;
  logic [COUNT_W-1:0]   old_next;
  logic [MAX_PAGES-1:0] page_mask;
  logic [COUNT_W-1:0]   pg_inc;
  logic                 needs_page;

  assign old_map   = ram_rdata[MAP_LSB +: MAX_PAGES];
  assign old_cond  = cond_e'(ram_rdata[COND_LSB +: COND_W]);
  assign old_wear  = ram_rdata[WEAR_LSB +: WEAR_W];
  assign old_valid = ram_rdata[VALID_LSB +: COUNT_W];
  assign old_next  = ram_rdata[NEXT_LSB +: COUNT_W];
  assign page_mask = PAGE_ONE << pg_q[PIDX_W-1:0];
  assign pg_inc    = pg_q + COUNT_W'(1);
  assign needs_page = (cmd_q == CMD_READ) || (cmd_q == CMD_PROGRAM);
  assign addr_ok   = block_ok_q && (page_ok_q || !needs_page);

  // Command execution on the block metadata
  logic [MAX_PAGES-1:0] new_map;
  cond_e                new_cond;
  logic [WEAR_W-1:0]    new_wear;
  logic [COUNT_W-1:0]   new_valid;
  logic [COUNT_W-1:0]   new_next;
  status_e              res_status;
  logic                 res_rf;
  logic                 res_pw;

  always_comb begin
    new_map    = old_map;
    new_cond   = old_cond;
    new_wear   = old_wear;
    new_valid  = old_valid;
    new_next   = old_next;
    res_status = ST_OK;
    res_rf     = 1'b0;
    case (cmd_q)
      CMD_READ: begin
        res_rf = fault_q;
      end
      CMD_PROGRAM: begin
        if (old_cond == COND_BAD) begin
          res_status = ST_DEV_ERR;
        end else if (|(old_map & page_mask)) begin
          res_status = ST_WRITTEN;
        end else if ((old_cond == COND_OPEN) && (pg_q != old_next)) begin
          res_status = ST_INVALID;
        end else if (fault_q) begin
          res_status = ST_DEV_ERR;
        end else begin
          new_map  = old_map | page_mask;
          new_next = pg_inc;
          if (old_valid != '1) begin
            new_valid = old_valid + COUNT_W'(1);
          end
          if (old_cond == COND_FREE) begin
            new_cond = COND_OPEN;
          end
          if (pg_inc >= n_pg) begin
            new_cond = COND_FULL;
          end
        end
      end
      CMD_ERASE: begin
        if (fault_q) begin
          new_cond   = COND_BAD;
          res_status = ST_DEV_ERR;
        end else begin
          new_map   = '0;
          new_cond  = COND_FREE;
          new_valid = '0;
          new_next  = '0;
          if (old_wear != '1) begin
            new_wear = old_wear + WEAR_W'(1);
          end
        end
      end
      CMD_MARK_BAD: begin
        new_cond = COND_BAD;
      end
      default: ;
    endcase
  end

  assign res_pw   = page_ok_q && (|(new_map & page_mask));
  assign meta_new = {new_next, new_valid, new_wear, new_cond, new_map};

  // Result register: status, page_written, cond, wear, valid, read_fault
  logic [M_TDATA_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (addr_ok) begin
        out_q <= M_TDATA_W'({res_rf, new_valid, new_wear, new_cond, res_pw, res_status});
      end else begin
        out_q <= M_TDATA_W'({1'b0, COUNT_W'(0), WEAR_W'(0), COND_BAD, 1'b0, ST_INVALID});
      end
    end
  end

  assign out_tdata_o = out_q;

endmodule

// File: hdl/nand_block_page_state_tracker.sv
// Result: the result register loads in the execute state after the command transfer,
//   later only while the previous result still waits on m_axis_tready.
// Flow: a new command is taken only in the idle state, once the previous one has
//   executed; the single metadata RAM is read at acceptance and written back in execute.
// Reset: rst_ni async, active low; a clearing sweep then zeroes the metadata RAM,
//   one entry per cycle (1024 entries at default limits), with s_axis_tready low.
module nand_block_page_state_tracker
  import nbpst_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_DIES     = DEF_MAX_DIES,
  parameter int MAX_PLANES   = DEF_MAX_PLANES,
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int MAX_PAGES    = DEF_MAX_PAGES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [1:0] command, [57:2] physical_address, [58] inject_fault, [63:59] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] status, [2] page_written, [4:3] block_condition, [24:5] wear_count,
  // [31:25] valid_count, [32] read_fault, [39:33] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  cfg_t       cfg;
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  nbpst_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nbpst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (ctrl_cmd),
    .status_i  (dp_status)
  );

  nbpst_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_DIES     (MAX_DIES),
    .MAX_PLANES   (MAX_PLANES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .MAX_PAGES    (MAX_PAGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .cfg_i       (cfg),
    .in_tdata_i  (s_axis_tdata),
    .out_tdata_o (m_axis_tdata)
  );

endmodule

// File: tb/nand_block_page_state_tracker_checker.sv
// Scoreboard for the NAND block/page state tracker: keeps its own copy of the
// geometry registers and per-block metadata, predicts each result and checks it.
// Depends on nbpst_pkg for field layout, codes and default limits.
`timescale 1ns / 1ps

module nand_block_page_state_tracker_checker
  import nbpst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  // result channel
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  // configuration port
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [APB_AW-1:0]    paddr_i,
  input  logic [APB_DW-1:0]    pwdata_i,
  input  logic [APB_DW-1:0]    prdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int BLK_ENTRIES = DEF_MAX_CHANNELS * DEF_MAX_DIES * DEF_MAX_PLANES * DEF_MAX_BLOCKS;
  localparam logic [WEAR_W-1:0]  WEAR_CEIL  = '1;
  localparam logic [COUNT_W-1:0] COUNT_CEIL = '1;

  // Result layout, lowest field last
  typedef struct packed {
    logic [M_TDATA_W-34:0] pad;
    logic                  rd_fault;
    logic [COUNT_W-1:0]    valid;
    logic [WEAR_W-1:0]     wear;
    cond_e                 cond;
    logic                  pw;
    status_e               st;
  } outcome_t;

  // Geometry registers and per-block metadata
  cfg_t               geo;
  logic [63:0]        page_bits [BLK_ENTRIES];
  cond_e              cond_tab  [BLK_ENTRIES];
  logic [WEAR_W-1:0]  erase_cnt [BLK_ENTRIES];
  logic [COUNT_W-1:0] prog_cnt  [BLK_ENTRIES];
  logic [COUNT_W-1:0] next_pg   [BLK_ENTRIES];

  outcome_t    outcome_q[$];
  int unsigned fails;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned top);
    return (v > top) ? top : v;
  endfunction

  // Apply one command to the metadata and return the reported outcome
  function automatic outcome_t apply_command(cmd_e c, logic [ADDR_W-1:0] a, logic f);
    outcome_t           r;
    logic [PG_W-1:0]    pg;
    logic [BLK_W-1:0]   blk;
    logic [PL_W-1:0]    pl;
    logic [DIE_W-1:0]   die;
    logic [CH_W-1:0]    ch;
    int unsigned        n_pg, bi;
    logic               blk_ok, pg_ok;
    logic [63:0]        mask;
    cond_e              cnow;
    pg   = a[PG_LSB +: PG_W];
    blk  = a[BLK_LSB +: BLK_W];
    pl   = a[PL_LSB +: PL_W];
    die  = a[DIE_LSB +: DIE_W];
    ch   = a[CH_LSB +: CH_W];
    n_pg = clamp_size(geo.pages, DEF_MAX_PAGES);
    blk_ok = (ch < clamp_size(geo.channels, DEF_MAX_CHANNELS))
          && (die < clamp_size(geo.dies, DEF_MAX_DIES))
          && (pl < clamp_size(geo.planes, DEF_MAX_PLANES))
          && (blk < clamp_size(geo.blocks, DEF_MAX_BLOCKS));
    pg_ok = pg < n_pg;
    r = '0;
    if (!blk_ok || ((c == CMD_READ || c == CMD_PROGRAM) && !pg_ok)) begin
      r.st   = ST_INVALID;
      r.cond = COND_BAD;
      return r;
    end
    bi   = ((ch * DEF_MAX_DIES + die) * DEF_MAX_PLANES + pl) * DEF_MAX_BLOCKS + blk;
    mask = 64'd1 << pg[5:0];
    r.st = ST_OK;
    case (c)
      CMD_READ: r.rd_fault = f;
      CMD_PROGRAM: begin
        cnow = cond_tab[bi];
        if (cnow == COND_BAD) begin
          r.st = ST_DEV_ERR;
        end else if ((page_bits[bi] & mask) != 0) begin
          r.st = ST_WRITTEN;
        end else if (cnow == COND_OPEN && pg != next_pg[bi]) begin
          r.st = ST_INVALID;
        end else if (f) begin
          r.st = ST_DEV_ERR;
        end else begin
          page_bits[bi] |= mask;
          if (prog_cnt[bi] != COUNT_CEIL) prog_cnt[bi]++;
          next_pg[bi] = COUNT_W'(pg + 1);
          if (cnow == COND_FREE) cond_tab[bi] = COND_OPEN;
          if (next_pg[bi] >= n_pg) cond_tab[bi] = COND_FULL;
        end
      end
      CMD_ERASE: begin
        if (f) begin
          cond_tab[bi] = COND_BAD;
          r.st = ST_DEV_ERR;
        end else begin
          page_bits[bi] = '0;
          cond_tab[bi]  = COND_FREE;
          if (erase_cnt[bi] != WEAR_CEIL) erase_cnt[bi]++;
          prog_cnt[bi] = '0;
          next_pg[bi]  = '0;
        end
      end
      default: cond_tab[bi] = COND_BAD;
    endcase
    r.pw    = pg_ok ? ((page_bits[bi] & mask) != 0) : 1'b0;
    r.cond  = cond_tab[bi];
    r.wear  = erase_cnt[bi];
    r.valid = prog_cnt[bi];
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t   exp_r, act_r;
    reg_idx_e   ridx;
    logic       mapped;
    logic [APB_DW-1:0] reg_val;
    if (!rst_ni) begin
      geo = '{channels: CFG_RST_CHANNELS, dies: CFG_RST_DIES, planes: CFG_RST_PLANES,
              blocks: CFG_RST_BLOCKS, pages: CFG_RST_PAGES};
      for (int i = 0; i < BLK_ENTRIES; i++) begin
        page_bits[i] = '0;
        cond_tab[i]  = COND_FREE;
        erase_cnt[i] = '0;
        prog_cnt[i]  = '0;
        next_pg[i]   = '0;
      end
      outcome_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register access
      if (psel_i && penable_i && pready_i) begin
        ridx    = reg_idx_e'(paddr_i[APB_AW-1:2]);
        mapped  = (paddr_i[1:0] == 2'b00);
        reg_val = '0;
        case (ridx)
          REG_CHANNELS: reg_val = APB_DW'(geo.channels);
          REG_DIES:     reg_val = APB_DW'(geo.dies);
          REG_PLANES:   reg_val = APB_DW'(geo.planes);
          REG_BLOCKS:   reg_val = APB_DW'(geo.blocks);
          REG_PAGES:    reg_val = APB_DW'(geo.pages);
          default:      mapped = 1'b0;
        endcase
        if (mapped && pwrite_i) begin
          case (ridx)
            REG_CHANNELS: geo.channels = pwdata_i[CFG_CH_W-1:0];
            REG_DIES:     geo.dies     = pwdata_i[CFG_DIE_W-1:0];
            REG_PLANES:   geo.planes   = pwdata_i[CFG_PL_W-1:0];
            REG_BLOCKS:   geo.blocks   = pwdata_i[CFG_BLK_W-1:0];
            REG_PAGES:    geo.pages    = pwdata_i[CFG_PG_W-1:0];
            default: ;
          endcase
        end else if (mapped) begin
          check_field("register readback", reg_val, prdata_i);
        end
      end
      // result transfer against the oldest outstanding outcome
      if (m_tvalid_i && m_tready_i) begin
        if (outcome_q.size() == 0) begin
          fails++;
          $display("%0t ns: result with no command outstanding, expected none, actual %h",
                   $time, m_tdata_i);
        end else begin
          exp_r = outcome_q.pop_front();
          act_r = outcome_t'(m_tdata_i);
          check_field("status", exp_r.st, act_r.st);
          check_field("page_written", exp_r.pw, act_r.pw);
          check_field("block_condition", exp_r.cond, act_r.cond);
          check_field("wear_count", exp_r.wear, act_r.wear);
          check_field("valid_count", exp_r.valid, act_r.valid);
          check_field("read_fault", exp_r.rd_fault, act_r.rd_fault);
          check_field("padding", exp_r.pad, act_r.pad);
        end
      end
      // command transfer
      if (s_tvalid_i && s_tready_i)
        outcome_q.push_back(apply_command(cmd_e'(s_tdata_i[IN_CMD_LSB +: CMD_W]),
                                          s_tdata_i[IN_ADDR_LSB +: ADDR_W],
                                          s_tdata_i[IN_FAULT_BIT]));
      pending_o    <= outcome_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: tb/nand_block_page_state_tracker_tb.sv
// Top of the page state tracker testbench: clock, reset, register setup and
// command/result stimulus with random gaps; checking is done in the checker module.
// Depends on nbpst_pkg, nand_block_page_state_tracker and its checker.
`timescale 1ns / 1ps

module nand_block_page_state_tracker_tb;
  import nbpst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_HOT     = 3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  int unsigned fail_count, results_pending;
  int unsigned cycle_count = 0;

  // stimulus shaping: max idle cycles per side, effective geometry, hot blocks
  int unsigned tx_max = 10, rx_max = 10;
  int unsigned eff_ch, eff_die, eff_pl, eff_blk, eff_pg;
  int unsigned hot_ch[NUM_HOT], hot_die[NUM_HOT], hot_pl[NUM_HOT], hot_blk[NUM_HOT];
  int unsigned hot_next[NUM_HOT];

  always #6 clk_i = ~clk_i;

  nand_block_page_state_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  nand_block_page_state_tracker_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL nand_block_page_state_tracker");
      $finish;
    end
  end

  // Result side: random stall before each transfer
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic logic [ADDR_W-1:0] mk_addr(int unsigned ch, int unsigned die,
                                                int unsigned pl, int unsigned blk,
                                                int unsigned pg);
    return {CH_W'(ch), DIE_W'(die), PL_W'(pl), BLK_W'(blk), PG_W'(pg)};
  endfunction

  function automatic int unsigned pick_index(int unsigned n);
    return (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 1);
  endfunction

  function automatic int unsigned min_u(int unsigned v, int unsigned top);
    return (v > top) ? top : v;
  endfunction

  // One command transfer after a random gap
  task automatic issue_cmd(cmd_e c, logic [ADDR_W-1:0] a, logic f);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({f, a, c});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off commands until every outstanding result has been taken
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  task automatic apb_access(reg_idx_e idx, logic wr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random junk above the register width must be dropped by the block
  task automatic set_reg(reg_idx_e idx, int unsigned value, int unsigned width);
    apb_access(idx, 1'b1, ($urandom() << width) | value);
  endtask

  task automatic set_geometry(int unsigned ch, int unsigned die, int unsigned pl,
                              int unsigned blk, int unsigned pg);
    set_reg(REG_CHANNELS, ch, CFG_CH_W);
    set_reg(REG_DIES, die, CFG_DIE_W);
    set_reg(REG_PLANES, pl, CFG_PL_W);
    set_reg(REG_BLOCKS, blk, CFG_BLK_W);
    set_reg(REG_PAGES, pg, CFG_PG_W);
    for (int i = 0; i <= int'(REG_PAGES); i++) apb_access(reg_idx_e'(i), 1'b0, '0);
    eff_ch  = min_u(ch, DEF_MAX_CHANNELS);
    eff_die = min_u(die, DEF_MAX_DIES);
    eff_pl  = min_u(pl, DEF_MAX_PLANES);
    eff_blk = min_u(blk, DEF_MAX_BLOCKS);
    eff_pg  = min_u(pg, DEF_MAX_PAGES);
    for (int h = 0; h < NUM_HOT; h++) begin
      hot_ch[h]   = pick_index(eff_ch);
      hot_die[h]  = pick_index(eff_die);
      hot_pl[h]   = pick_index(eff_pl);
      hot_blk[h]  = pick_index(min_u(eff_blk, 4));
      hot_next[h] = 0;
    end
  endtask

  // Mostly in-order traffic on a few hot blocks, the rest random noise
  task automatic run_phase(int unsigned ch, int unsigned die, int unsigned pl,
                           int unsigned blk, int unsigned pg, int unsigned n_items);
    int unsigned roll, h, page;
    cmd_e c;
    logic f;
    logic [ADDR_W-1:0] a;
    set_geometry(ch, die, pl, blk, pg);
    tx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
    rx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 82) begin
        h    = $urandom_range(0, NUM_HOT - 1);
        roll = $urandom_range(0, 99);
        f    = ($urandom_range(0, 99) < 8);
        if (roll < 50) c = CMD_PROGRAM;
        else if (roll < 75) c = CMD_READ;
        else if (roll < 92) c = CMD_ERASE;
        else c = CMD_MARK_BAD;
        case (c)
          CMD_PROGRAM: page = ($urandom_range(0, 9) < 7) ? hot_next[h]
                                                          : $urandom_range(0, eff_pg);
          CMD_READ:    page = ($urandom_range(0, 9) == 0) ? eff_pg : pick_index(eff_pg);
          default:     page = $urandom_range(0, 16'hFFFF);
        endcase
        a = mk_addr(hot_ch[h], hot_die[h], hot_pl[h], hot_blk[h], page);
        if (c == CMD_PROGRAM && !f) hot_next[h] = (page + 1 >= eff_pg) ? 0 : page + 1;
        if (c == CMD_ERASE && !f) hot_next[h] = 0;
      end else begin
        c = cmd_e'($urandom_range(0, 3));
        f = $urandom_range(0, 1);
        if ($urandom_range(0, 1)) begin
          a = ADDR_W'({$urandom(), $urandom()});
        end else begin
          a = mk_addr($urandom_range(0, eff_ch + 1), $urandom_range(0, eff_die + 1),
                      $urandom_range(0, eff_pl + 1), $urandom_range(0, eff_blk + 1),
                      $urandom_range(0, eff_pg + 1));
        end
      end
      issue_cmd(c, a, f);
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small pages per block so a block fills quickly
    set_geometry(4, 2, 2, 64, 4);
    issue_cmd(CMD_READ, mk_addr(0, 0, 0, 0, 0), 1'b0);
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 0), 1'b0);
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 0), 1'b0);  // overwrite refused
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 2), 1'b0);  // skips next page in open block
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 1), 1'b1);  // device fault
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 1), 1'b0);
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 2), 1'b0);
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 3), 1'b0);  // block goes full
    issue_cmd(CMD_READ, mk_addr(0, 0, 0, 0, 3), 1'b1);     // read with injected error
    issue_cmd(CMD_READ, mk_addr(0, 0, 0, 0, 4), 1'b0);     // page past geometry
    issue_cmd(CMD_ERASE, mk_addr(0, 0, 0, 0, 16'hFFFF), 1'b0);
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 2), 1'b0);  // free block takes any page
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 3), 1'b0);
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 0), 1'b0);  // full block takes a free page
    issue_cmd(CMD_ERASE, mk_addr(0, 0, 0, 0, 0), 1'b1);    // faulted erase marks bad
    issue_cmd(CMD_READ, mk_addr(0, 0, 0, 0, 0), 1'b0);     // read still works in bad block
    issue_cmd(CMD_PROGRAM, mk_addr(0, 0, 0, 0, 1), 1'b0);  // bad block refuses program
    issue_cmd(CMD_ERASE, mk_addr(0, 0, 0, 0, 1), 1'b0);    // erase revives bad block
    issue_cmd(CMD_MARK_BAD, mk_addr(0, 0, 0, 0, 1), 1'b1);
    issue_cmd(CMD_READ, mk_addr(3, 1, 1, 63, 3), 1'b1);    // top corner of geometry
    issue_cmd(CMD_READ, mk_addr(4, 0, 0, 0, 0), 1'b0);
    issue_cmd(CMD_PROGRAM, mk_addr(0, 2, 0, 0, 0), 1'b0);
    issue_cmd(CMD_ERASE, mk_addr(0, 0, 2, 0, 0), 1'b0);
    issue_cmd(CMD_MARK_BAD, mk_addr(0, 0, 0, 64, 0), 1'b1);
    issue_cmd(CMD_MARK_BAD, '1, 1'b1);
    wait_drained();

    // Random phases over several geometries, extremes included
    run_phase(1, 1, 1, 1, 1, 120);
    run_phase(4, 2, 2, 64, 64, 200);
    run_phase(7, 3, 3, 127, 127, 150);
    run_phase(2, 2, 1, 4, 3, 200);
    run_phase(0, 2, 2, 64, 64, 40);
    run_phase(4, 2, 2, 8, 6, 200);
    run_phase(3, 1, 2, 2, 2, 200);
    run_phase(1, 2, 1, 3, 0, 40);
    run_phase($urandom_range(1, 7), $urandom_range(1, 3), $urandom_range(1, 3),
              $urandom_range(1, 127), $urandom_range(1, 16), 150);

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS nand_block_page_state_tracker");
    end else begin
      $display("FAIL nand_block_page_state_tracker");
    end
    $finish;
  end

endmodule
